// ===== sv/twfaw_pkg.sv =====
`default_nettype none
package twfaw_pkg;

	typedef struct packed {
		logic [9:0]  ground_speed;
		logic [9:0]  apparent_speed;
		logic [11:0] apparent_angle;
		logic [11:0] course;
		logic [4:0]  utc_hour;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [10:0] true_speed;
		logic [10:0] true_angle;
		logic [10:0] max_speed;
		logic [4:0]  local_hour;
		logic [8:0]  course_plus;
		logic [8:0]  course_minus;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MS, ST_MX, ST_MZ, ST_ROT, ST_ADJ, ST_VEC, ST_MMAG, ST_MANG, ST_FIN
	} state_t;

	localparam logic [1:0] CFG_WIND_FLOOR = 2'd0;
	localparam logic [1:0] CFG_MAX_WINDOW = 2'd1;
	localparam logic [1:0] CFG_ZONE       = 2'd2;

	localparam int          ATAN_COUNT    = 28;
	localparam logic [29:0] GAIN_Q30      = 30'd652032874;
	localparam logic [29:0] DEG10_RAD_Q30 = 30'd1874033;
	localparam logic [29:0] KNOT_MS_Q30   = 30'd552380516;
	localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
	localparam logic [29:0] RAD_DEG10_Q20 = 30'd600789793;
	localparam logic [29:0] GAIN_Q24      = 30'd10188014;

	localparam logic [29:0] ATAN_Q30 [ATAN_COUNT] = '{
		30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8
	};

endpackage
`default_nettype wire

// ===== sv/twfaw_cordic_step.sv =====
`default_nettype none
module twfaw_cordic_step import twfaw_pkg::*; #(
	parameter int W = 30
) (
	input  wire logic                 vectoring,
	input  wire logic [4:0]           shift,
	input  wire logic signed [W-1:0]  x,
	input  wire logic signed [W-1:0]  y,
	input  wire logic signed [W-1:0]  z,
	input  wire logic signed [W-1:0]  t,
	output logic signed [W-1:0]       x_next,
	output logic signed [W-1:0]       y_next,
	output logic signed [W-1:0]       z_next
);
	logic pos;
	logic signed [W-1:0] xs, ys;

	always_comb begin
		pos = vectoring ? y[W-1] : !z[W-1];
		xs  = x >>> shift;
		ys  = y >>> shift;
		if (pos) begin
			x_next = x - ys;
			y_next = y + xs;
			z_next = z - t;
		end else begin
			x_next = x + ys;
			y_next = y - xs;
			z_next = z + t;
		end
	end
endmodule
`default_nettype wire

// ===== sv/true_wind_from_apparent_wind.sv =====
// true wind from apparent wind, iterative cordic
// input channel in_valid / in_stall carries one in_word_t; output channel
// out_valid / out_stall carries one out_word_t per input word
// config channel cfg_valid / cfg_ready (always ready): cfg_index selects
// wind floor, max window or zone offset, cfg_data holds the value
// the result is loaded into the output register after a rotation pass and a
// vectoring pass of the cordic step and the multiplies; a new word is taken only
// in the idle state that follows each result, so words do not overlap;
// the shift-add cordic step and the multiplier are single shared instances
// in_stall stays high from acceptance until the result is in the output
// register; a stalled result holds, and a finished word waits for it
// at reset: floor 2, window 600000 ms, zone +2, held maximum and its time 0
// the held maximum is replaced when it is older than the window or exceeded
`default_nettype none
module true_wind_from_apparent_wind import twfaw_pkg::*; #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 18
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [21:0] cfg_data
);
	localparam int W     = FRAC_BITS + 14;
	localparam int PW    = W + 30;
	localparam int STEPS = CORDIC_STEPS > ATAN_COUNT ? ATAN_COUNT : CORDIC_STEPS;
	localparam int SH    = 30 - FRAC_BITS;
	localparam logic [PW-1:0] RND30 = PW'(1) << (29 - FRAC_BITS);
	localparam logic signed [W-1:0] HALF_PI_F =
		W'((64'(HALF_PI_Q30) + (64'd1 << (29 - FRAC_BITS))) >> SH);

	state_t state_q, state_d;
	in_word_t in_q;
	logic [6:0]  floor_q;
	logic [21:0] window_q;
	logic signed [4:0] zone_q;
	logic [10:0] held_q;
	logic [31:0] held_time_q;
	logic [4:0]  cnt_q;
	logic        flip_q;
	logic signed [W-1:0] s_q, x_q, y_q, z_q, base_q;
	logic [W-1:0] mag_q;
	logic [10:0]  ang_res_q;
	logic [11:0]  ang_mod, ang_red, crs_mod;

	// shared multiplier
	logic [W-1:0]  mul_a;
	logic [29:0]   mul_b;
	logic [PW-1:0] prod, prod_q30;

	logic signed [W-1:0] t_cur, xn, yn, zn, xf, xs, tot;
	logic [29:0] atan_e;
	logic last_step;

	always_comb begin
		ang_mod = in_q.apparent_angle >= 12'd3600 ? in_q.apparent_angle - 12'd3600
			: in_q.apparent_angle;
		ang_red = ang_mod > 12'd1800 ? 12'd3600 - ang_mod : ang_mod;
		if (ang_red > 12'd900) ang_red = 12'd1800 - ang_red;
		crs_mod = in_q.course >= 12'd3600 ? in_q.course - 12'd3600 : in_q.course;
		atan_e = ATAN_Q30[cnt_q];
		t_cur = W'((32'(atan_e) + (32'd1 << (29 - FRAC_BITS))) >> SH);
		last_step = cnt_q == 5'(STEPS - 1);
		tot = z_q + base_q;
		if (tot[W-1]) tot = '0;
		xf = flip_q ? -x_q : x_q;
		xs = xf - s_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MS: begin
				mul_a = W'(in_q.ground_speed);
				mul_b = KNOT_MS_Q30;
			end
			ST_MX: begin
				mul_a = W'(in_q.apparent_speed);
				mul_b = GAIN_Q30;
			end
			ST_MZ: begin
				mul_a = W'(ang_red);
				mul_b = DEG10_RAD_Q30;
			end
			ST_MMAG: begin
				mul_a = x_q[W-1] ? '0 : x_q;
				mul_b = GAIN_Q24;
			end
			ST_MANG: begin
				mul_a = tot;
				mul_b = RAD_DEG10_Q20;
			end
			default: ;
		endcase
		prod = PW'(mul_a) * PW'(mul_b);
		prod_q30 = (prod + RND30) >> SH;
	end

	twfaw_cordic_step #(.W(W)) u_step (
		.vectoring(state_q == ST_VEC),
		.shift(cnt_q),
		.x(x_q), .y(y_q), .z(z_q), .t(t_cur),
		.x_next(xn), .y_next(yn), .z_next(zn)
	);

	// result assembly
	logic [W-1:0] floor_f, r_full, held_f;
	logic [PW-1:0] ang_full;
	logic floored;
	logic [10:0] speed, held1, held2;
	logic [31:0] time1, time2;
	logic signed [6:0] lh;
	logic [12:0] cp, cm, cpr, cmr;
	logic [26:0] cpq, cmq;
	logic [8:0] cpd, cmd;
	logic out_load;

	always_comb begin
		ang_full = (prod + (PW'(1) << (FRAC_BITS + 19))) >> (FRAC_BITS + 20);
		floor_f = W'(floor_q) << FRAC_BITS;
		floored = mag_q <= floor_f;
		r_full = (mag_q + (W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		speed = floored ? 11'd0 : (r_full > W'(2047) ? 11'd2047 : r_full[10:0]);
		held1 = held_q;
		time1 = held_time_q;
		if ((in_q.now_ms - 32'(window_q)) > held_time_q) begin
			held1 = speed;
			time1 = in_q.now_ms;
		end
		held_f = W'(held1) << FRAC_BITS;
		held2 = held1;
		time2 = time1;
		if (!floored && mag_q > held_f) begin
			held2 = speed;
			time2 = in_q.now_ms;
		end
		lh = 7'(in_q.utc_hour) + 7'(zone_q);
		if (lh < 0) lh = lh + 7'sd24;
		else if (lh >= 7'sd24) lh = lh - 7'sd24;
		cp = 13'(crs_mod) + 13'd450;
		if (cp >= 13'd3600) cp = cp - 13'd3600;
		cm = 13'(crs_mod) + 13'd3150;
		if (cm >= 13'd3600) cm = cm - 13'd3600;
		cpr = cp + 13'd5;
		cmr = cm + 13'd5;
		cpq = 27'(cpr) * 27'd6554;
		cmq = 27'(cmr) * 27'd6554;
		cpd = cpq[24:16] >= 9'd360 ? cpq[24:16] - 9'd360 : cpq[24:16];
		cmd = cmq[24:16] >= 9'd360 ? cmq[24:16] - 9'd360 : cmq[24:16];
		out_load = state_q == ST_FIN && (!out_valid || !out_stall);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MS;
			ST_MS:   state_d = ST_MX;
			ST_MX:   state_d = ST_MZ;
			ST_MZ:   state_d = ST_ROT;
			ST_ROT:  if (last_step) state_d = ST_ADJ;
			ST_ADJ:  state_d = ST_VEC;
			ST_VEC:  if (last_step) state_d = ST_MMAG;
			ST_MMAG: state_d = ST_MANG;
			ST_MANG: state_d = ST_FIN;
			ST_FIN:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			floor_q     <= 7'd2;
			window_q    <= 22'd600000;
			zone_q      <= 5'sd2;
			held_q      <= '0;
			held_time_q <= '0;
			cnt_q       <= '0;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_WIND_FLOOR: floor_q  <= cfg_data[6:0];
					CFG_MAX_WINDOW: window_q <= cfg_data;
					CFG_ZONE:       zone_q   <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (state_q == ST_ROT || state_q == ST_VEC)
				cnt_q <= last_step ? 5'd0 : cnt_q + 5'd1;
			if (out_load) begin
				out_valid   <= 1'b1;
				held_q      <= held2;
				held_time_q <= time2;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) in_q <= in_data;
		case (state_q)
			ST_MS: s_q <= W'(prod_q30);
			ST_MX: begin
				x_q <= W'(prod_q30);
				y_q <= '0;
				flip_q <= ang_mod > 12'd1800 ? (12'd3600 - ang_mod) > 12'd900
					: ang_mod > 12'd900;
			end
			ST_MZ: z_q <= W'(prod_q30);
			ST_ROT, ST_VEC: begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
			end
			ST_ADJ: begin
				z_q <= '0;
				if (xs[W-1]) begin
					x_q    <= y_q[W-1] ? -y_q : y_q;
					y_q    <= -xs;
					base_q <= HALF_PI_F;
				end else begin
					x_q    <= xs;
					y_q    <= y_q[W-1] ? -y_q : y_q;
					base_q <= '0;
				end
			end
			ST_MMAG: mag_q <= W'((prod + (PW'(1) << 23)) >> 24);
			ST_MANG: ang_res_q <= ang_full > PW'(1800) ? 11'd1800 : ang_full[10:0];
			default: ;
		endcase
		if (out_load) begin
			out_data.true_speed   <= speed;
			out_data.true_angle   <= floored ? 11'd0 : ang_res_q;
			out_data.max_speed    <= held2;
			out_data.local_hour   <= lh[4:0];
			out_data.course_plus  <= cpd;
			out_data.course_minus <= cmd;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < 5'(STEPS)) else $error("cordic step count out of range");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN)) else $error("result without finish");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == ST_MS) else $error("accept did not start");

endmodule
`default_nettype wire

// ===== sim/true_wind_from_apparent_wind_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module true_wind_from_apparent_wind_test;
	import twfaw_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 400;

	class wind_scoreboard;
		out_word_t expected_words[$];
		int errors;
		logic [6:0]  floor_cfg;
		logic [21:0] window_cfg;
		int          zone_cfg;
		logic [10:0] held_max;
		logic [31:0] held_time;

		function new();
			errors = 0;
			floor_cfg = 7'd2;
			window_cfg = 22'd600000;
			zone_cfg = 2;
			held_max = '0;
			held_time = '0;
		endfunction

		function longint to_frac(longint v);
			return (v + (64'sd1 <<< 13)) >>> 14;
		endfunction

		function logic [8:0] whole_deg(longint tenths);
			longint d;
			d = (tenths + 5) / 10;
			return (d >= 360) ? 9'(d - 360) : 9'(d);
		endfunction

		function void set_reg(logic [1:0] idx, logic [21:0] val);
			if (idx == CFG_WIND_FLOOR)
				floor_cfg = val[6:0];
			else if (idx == CFG_MAX_WINDOW)
				window_cfg = val;
			else if (idx == CFG_ZONE)
				zone_cfg = int'($signed(val[4:0]));
		endfunction

		function out_word_t wind_solution(in_word_t w);
			longint g, a, ang, crs, s, x, y, z, vx, vy, base, mag, spq, t, nx, r, tot, cp, cm;
			int hour, lh;
			bit flip;
			logic [31:0] now, age;
			logic [10:0] spd, angl;
			out_word_t o;
			g = longint'(w.ground_speed);
			a = longint'(w.apparent_speed);
			ang = longint'(w.apparent_angle) % 3600;
			crs = longint'(w.course) % 3600;
			hour = int'(w.utc_hour);
			now = w.now_ms;
			flip = 0;
			spd = '0;
			angl = '0;
			s = to_frac(g * longint'(KNOT_MS_Q30));
			if (ang > 1800)
				ang = 3600 - ang;
			if (ang > 900) begin
				ang = 1800 - ang;
				flip = 1;
			end
			x = to_frac(a * longint'(GAIN_Q30));
			y = 0;
			z = to_frac(ang * longint'(DEG10_RAD_Q30));
			for (int i = 0; i < 18; i++) begin
				t = to_frac(longint'(ATAN_Q30[i]));
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= t;
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += t;
				end
				x = nx;
			end
			x = (flip ? -x : x) - s;
			if (y < 0)
				y = -y;
			if (x < 0) begin
				vx = y;
				vy = -x;
				base = to_frac(longint'(HALF_PI_Q30));
			end else begin
				vx = x;
				vy = y;
				base = 0;
			end
			z = 0;
			for (int i = 0; i < 18; i++) begin
				t = to_frac(longint'(ATAN_Q30[i]));
				if (vy >= 0) begin
					nx = vx + (vy >>> i);
					vy = vy - (vx >>> i);
					z += t;
				end else begin
					nx = vx - (vy >>> i);
					vy = vy + (vx >>> i);
					z -= t;
				end
				vx = nx;
			end
			if (vx < 0)
				vx = 0;
			mag = (vx * longint'(GAIN_Q24) + (64'sd1 <<< 23)) >>> 24;
			if (mag <= (longint'(floor_cfg) <<< 16)) begin
				spq = 0;
			end else begin
				r = (mag + (64'sd1 <<< 15)) >>> 16;
				tot = z + base;
				spq = mag;
				spd = (r > 2047) ? 11'd2047 : 11'(r);
				if (tot < 0)
					tot = 0;
				tot = (tot * longint'(RAD_DEG10_Q20) + (64'sd1 <<< 35)) >>> 36;
				angl = (tot > 1800) ? 11'd1800 : 11'(tot);
			end
			age = now - 32'(window_cfg);
			if (age > held_time) begin
				held_max = spd;
				held_time = now;
			end
			if (spq > (longint'(held_max) <<< 16)) begin
				held_max = spd;
				held_time = now;
			end
			lh = (hour + zone_cfg) % 24;
			if (lh < 0)
				lh += 24;
			cp = crs + 450;
			if (cp >= 3600)
				cp -= 3600;
			cm = crs - 450;
			if (cm < 0)
				cm += 3600;
			o.true_speed = spd;
			o.true_angle = angl;
			o.max_speed = held_max;
			o.local_hour = 5'(lh);
			o.course_plus = whole_deg(cp);
			o.course_minus = whole_deg(cm);
			return o;
		endfunction

		function void note_input(in_word_t w);
			expected_words.push_back(wind_solution(w));
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
			errors++;
		endtask

		task check_result(out_word_t o);
			out_word_t e;
			if (expected_words.size() == 0) begin
				report("unexpected word", o, 0);
				return;
			end
			e = expected_words.pop_front();
			if (o.true_speed !== e.true_speed) report("true_speed", o.true_speed, e.true_speed);
			if (o.true_angle !== e.true_angle) report("true_angle", o.true_angle, e.true_angle);
			if (o.max_speed !== e.max_speed) report("max_speed", o.max_speed, e.max_speed);
			if (o.local_hour !== e.local_hour) report("local_hour", o.local_hour, e.local_hour);
			if (o.course_plus !== e.course_plus)
				report("course_plus", o.course_plus, e.course_plus);
			if (o.course_minus !== e.course_minus)
				report("course_minus", o.course_minus, e.course_minus);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_word_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [21:0] cfg_data = '0;

	wind_scoreboard wind_sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [31:0] clock_ms = 0;

	true_wind_from_apparent_wind u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			wind_sb.note_input(in_data);
		if (arst_n && out_valid && !out_stall)
			wind_sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("true_wind_from_apparent_wind_test: FAIL");
			$finish;
		end
	end

	// receiver stalls, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task send_word(in_word_t w);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (wind_sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [21:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		wind_sb.set_reg(idx, val);
	endtask

	function in_word_t make_word(logic [9:0] g, logic [9:0] a, logic [11:0] ang,
			logic [11:0] crs, logic [4:0] h, logic [31:0] now);
		in_word_t w;
		w.ground_speed = g;
		w.apparent_speed = a;
		w.apparent_angle = ang;
		w.course = crs;
		w.utc_hour = h;
		w.now_ms = now;
		return w;
	endfunction

	function in_word_t random_word();
		in_word_t w;
		if ($urandom_range(0, 99) < 15) begin
			clock_ms = clock_ms + $urandom;
		end else begin
			clock_ms = clock_ms + $urandom_range(0, 300000);
		end
		if ($urandom_range(0, 99) < 20) begin
			w = in_word_t'({$urandom, $urandom, 17'($urandom)});
		end else begin
			w.ground_speed = 10'($urandom_range(0, 1000));
			w.apparent_speed = 10'($urandom_range(0, 1000));
			w.apparent_angle = 12'($urandom_range(0, 3600));
			w.course = 12'($urandom_range(0, 3599));
			w.utc_hour = 5'($urandom_range(0, 23));
			if ($urandom_range(0, 9) == 0)
				w.ground_speed = 10'($urandom_range(0, 40));
		end
		w.now_ms = clock_ms;
		return w;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		send_word(make_word(0, 0, 0, 0, 0, 0));
		send_word(make_word(0, 1000, 0, 3599, 23, 1));
		send_word(make_word(1000, 0, 1800, 3145, 0, 500));
		send_word(make_word(1000, 1000, 1800, 445, 31, 700000));
		send_word(make_word(1023, 1023, 4095, 4095, 24, 32'hffff_ffff));
		send_word(make_word(100, 500, 900, 3595, 12, 32'h8000_0000));
		send_word(make_word(500, 100, 900, 450, 5, 32'h8000_1000));
		send_word(make_word(200, 300, 2700, 1800, 18, 32'h8000_2000));
		send_word(make_word(300, 300, 3600, 3600, 7, 32'h8010_0000));
		send_word(make_word(0, 3, 450, 1234, 1, 32'h8020_0000));
		send_word(make_word(0, 2, 1350, 2222, 30, 32'h8020_0001));
		send_word(make_word(800, 50, 10, 5, 22, 32'h0000_0005));
		send_word(make_word(50, 800, 3590, 4, 2, 32'h0000_0006));
		send_word(make_word(1000, 1000, 1799, 3599, 23, 32'hfff0_0000));
		send_word(make_word(600, 900, 3000, 1000, 9, 32'hfff0_0001));
		clock_ms = 32'hfff0_0002;

		for (int phase = 0; phase < 8; phase++) begin
			drain();
			case (phase)
				0: begin
					write_reg(CFG_WIND_FLOOR, 22'd0);
					write_reg(CFG_MAX_WINDOW, 22'd1000);
					write_reg(CFG_ZONE, 22'(-12));
				end
				1: begin
					write_reg(CFG_WIND_FLOOR, 22'd100);
					write_reg(CFG_MAX_WINDOW, 22'd3600000);
					write_reg(CFG_ZONE, 22'd14);
				end
				3: begin
					write_reg(CFG_WIND_FLOOR, 22'd127);
					write_reg(CFG_MAX_WINDOW, 22'h3fffff);
					write_reg(CFG_ZONE, 22'h10);
				end
				7: begin
					write_reg(CFG_WIND_FLOOR, 22'd2);
					write_reg(CFG_MAX_WINDOW, 22'd600000);
					write_reg(CFG_ZONE, 22'h0f);
				end
				default: begin
					write_reg(CFG_WIND_FLOOR, 22'($urandom_range(0, 100)));
					write_reg(CFG_MAX_WINDOW, 22'($urandom_range(1000, 3600000)));
					write_reg(CFG_ZONE, 22'($urandom_range(0, 26) - 12));
				end
			endcase
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 76; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 76; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			for (int n = 0; n < 92; n++) begin
				if (phase == 2 && n == 40)
					hold_left = HOLD_CYCLES;
				if (phase == 5 && n == 40) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (wind_sb.expected_words.size() != 0)
						@(posedge clk);
				end
				send_word(random_word());
			end
		end

		send_idle_pct = 0;
		stall_pct = 0;
		drain();
		if (wind_sb.errors == 0)
			$display("true_wind_from_apparent_wind_test: PASS");
		else
			$display("true_wind_from_apparent_wind_test: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
sv/twfaw_pkg.sv
sv/twfaw_cordic_step.sv
sv/true_wind_from_apparent_wind.sv
sim/true_wind_from_apparent_wind_test.sv
